// File: rtl/core/rcft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcft_pkg
// Shared constants and types of the floor and ceiling texel caster.
// ----------------------------------------------------------------------------
package rcft_pkg;

    localparam int SCREEN_HEIGHT = 480;
    localparam int SCREEN_WIDTH  = 640;
    localparam int TEX_LOG2      = 6;
    localparam int TEX_SIZE      = 1 << TEX_LOG2;
    localparam int DIV_STAGES    = 6;

    localparam logic [23:0] Q_MAX  = 24'hFFFFFF;
    localparam logic [16:0] Q_ONE  = 17'h10000;
    localparam logic [23:0] HALF_MASK = 24'h7F7F7F;
    localparam logic [39:0] CD_NUM = 40'(SCREEN_HEIGHT) << 16;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_CAST = 1'b1;

    localparam logic [1:0] TEX_FLOOR_A = 2'd0;
    localparam logic [1:0] TEX_FLOOR_B = 2'd1;
    localparam logic [1:0] TEX_CEILING = 2'd2;

    typedef struct packed {
        logic        is_cast;
        logic        bad;
        logic [1:0]  sel;
        logic [11:0] tex_index;
        logic [31:0] texel;
        logic [9:0]  column;
        logic [9:0]  row;
        logic [23:0] wall_dist;
        logic [23:0] floor_x;
        logic [23:0] floor_y;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
    } item_t;

endpackage
`default_nettype wire

// File: rtl/core/raycast_floor_ceiling_texel_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// raycast_floor_ceiling_texel_core
// Floor and ceiling texel caster: one floor row of one column per word, with
// texel loads into the texture store travelling through the same pipeline.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                          tuser
// s_        in   loads and cast rows, 184 bits  {tex_sel, mode}
// m_        out  pixel pair, 88 bits            status
//
// One word is taken every cycle while the output is not stalled; a cast word's
// result passes through the input register, two six-stage dividers, the
// multiply stage, the memory read and the output register.
// Load words write the store at the same stage where casts read it.
// A stall at the output holds the whole pipeline; nothing is lost or repeated.
// Reset clears the valid bits only; the texture store is not cleared.
// ----------------------------------------------------------------------------
module raycast_floor_ceiling_texel_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tex_index, texel, column, row, wall_dist, floor_x, floor_y, pos_x, pos_y
    input  wire logic [183:0] s_tdata,
    // mode, tex_sel
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_column, floor_row, floor_color, ceiling_row, ceiling_color, pad
    output logic      [87:0]  m_tdata,
    // status
    output logic      [0:0]   m_tuser
);

    localparam int N = rcft_pkg::DIV_STAGES;

    logic adv;
    rcft_pkg::item_t in_item;

    rcft_pkg::item_t st0_reg;
    logic            v0_reg;
    rcft_pkg::item_t p1_reg [0:N-1];
    logic            v1_reg [0:N-1];
    rcft_pkg::item_t p2_reg [0:N-1];
    logic            v2_reg [0:N-1];
    rcft_pkg::item_t pm_reg;
    logic            vm_reg;
    logic [40:0]     ax_reg, bx_reg, ay_reg, by_reg;
    rcft_pkg::item_t pr_reg;
    logic            vr_reg;
    logic            out_valid_reg;
    logic [87:0]     out_data_reg;
    logic            out_status_reg;

    logic [10:0] denom_full;
    logic [23:0] q1, q2;
    logic        ovf1, ovf2;
    logic [23:0] cd;
    logic [16:0] w, omw;
    logic [41:0] sum_x, sum_y;
    logic [24:0] cfx, cfy;
    logic [11:0] ti;
    logic        parity;
    logic [31:0] floor_q, ceil_q;
    logic [10:0] ceil_row_full;
    logic [87:0] out_data_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_comb begin
        in_item.is_cast   = (s_tuser[0] == rcft_pkg::MODE_CAST);
        in_item.sel       = s_tuser[2:1];
        in_item.tex_index = s_tdata[11:0];
        in_item.texel     = s_tdata[43:12];
        in_item.column    = s_tdata[53:44];
        in_item.row       = s_tdata[63:54];
        in_item.wall_dist = s_tdata[87:64];
        in_item.floor_x   = s_tdata[111:88];
        in_item.floor_y   = s_tdata[135:112];
        in_item.pos_x     = s_tdata[159:136];
        in_item.pos_y     = s_tdata[183:160];
        in_item.bad       = (12'({s_tdata[63:54], 1'b0}) <= 12'(rcft_pkg::SCREEN_HEIGHT))
                         || (11'(s_tdata[63:54]) >= 11'(rcft_pkg::SCREEN_HEIGHT))
                         || (11'(s_tdata[53:44]) >= 11'(rcft_pkg::SCREEN_WIDTH));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st0_reg <= in_item;
            p1_reg[0] <= st0_reg;
            p2_reg[0] <= p1_reg[N-1];
            for (int s = 1; s < N; s++) begin
                p1_reg[s] <= p1_reg[s-1];
                p2_reg[s] <= p2_reg[s-1];
            end
            pm_reg <= p2_reg[N-1];
            ax_reg <= 41'(w) * 41'(p2_reg[N-1].floor_x);
            bx_reg <= 41'(omw) * 41'(p2_reg[N-1].pos_x);
            ay_reg <= 41'(w) * 41'(p2_reg[N-1].floor_y);
            by_reg <= 41'(omw) * 41'(p2_reg[N-1].pos_y);
            pr_reg <= pm_reg;
            out_data_reg   <= out_data_next;
            out_status_reg <= pr_reg.bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            vr_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < N; s++) begin
                v1_reg[s] <= 1'b0;
                v2_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            v0_reg    <= s_tvalid;
            v1_reg[0] <= v0_reg;
            v2_reg[0] <= v1_reg[N-1];
            for (int s = 1; s < N; s++) begin
                v1_reg[s] <= v1_reg[s-1];
                v2_reg[s] <= v2_reg[s-1];
            end
            vm_reg        <= v2_reg[N-1];
            vr_reg        <= vm_reg;
            out_valid_reg <= vr_reg && pr_reg.is_cast;
        end
    end

    assign denom_full = 11'({st0_reg.row, 1'b0}) - 11'(rcft_pkg::SCREEN_HEIGHT);

    rcft_div u_div_cd (
        .aclk     (aclk),
        .en       (adv),
        .dividend (rcft_pkg::CD_NUM),
        .divisor  ({14'd0, denom_full[9:0]}),
        .quotient (q1),
        .ovf      (ovf1)
    );

    assign cd = ovf1 ? rcft_pkg::Q_MAX : q1;

    rcft_div u_div_w (
        .aclk     (aclk),
        .en       (adv),
        .dividend ({cd, 16'd0}),
        .divisor  (p1_reg[N-1].wall_dist),
        .quotient (q2),
        .ovf      (ovf2)
    );

    assign w   = (ovf2 || q2 > 24'(rcft_pkg::Q_ONE)) ? rcft_pkg::Q_ONE : q2[16:0];
    assign omw = rcft_pkg::Q_ONE - w;

    assign sum_x  = 42'(ax_reg) + 42'(bx_reg);
    assign sum_y  = 42'(ay_reg) + 42'(by_reg);
    assign cfx    = sum_x[40:16];
    assign cfy    = sum_y[40:16];
    assign ti     = 12'({cfy[15 -: rcft_pkg::TEX_LOG2], cfx[15 -: rcft_pkg::TEX_LOG2]});
    assign parity = cfx[16] ^ cfy[16];

    rcft_tex_mem u_tex_mem (
        .aclk      (aclk),
        .en        (adv),
        .load      (vm_reg && !pm_reg.is_cast),
        .sel       (pm_reg.sel),
        .wr_index  (pm_reg.tex_index),
        .wr_data   (pm_reg.texel),
        .rd_parity (parity),
        .rd_index  (ti),
        .floor_q   (floor_q),
        .ceil_q    (ceil_q)
    );

    assign ceil_row_full = 11'(rcft_pkg::SCREEN_HEIGHT) - 11'(pr_reg.row);

    always_comb begin
        out_data_next        = 88'd0;
        out_data_next[9:0]   = pr_reg.column;
        out_data_next[19:10] = pr_reg.row;
        if (!pr_reg.bad) begin
            out_data_next[43:20] = floor_q[24:1] & rcft_pkg::HALF_MASK;
            out_data_next[53:44] = ceil_row_full[9:0];
            out_data_next[85:54] = ceil_q;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[85:20] == 66'd0)
        else $error("invalid row carries pixel data");

    a_rows_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            11'(m_tdata[53:44]) + 11'(m_tdata[19:10]) == 11'(rcft_pkg::SCREEN_HEIGHT))
        else $error("ceiling row does not mirror floor row");

    a_halved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[43] && !m_tdata[35] && !m_tdata[27])
        else $error("floor colour not halved");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting word");

endmodule
`default_nettype wire

// File: rtl/core/rcft_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcft_div
// Pipelined restoring divider, four quotient bits per stage, with a flag for
// quotients that do not fit in 24 bits.
// ----------------------------------------------------------------------------
module rcft_div (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [39:0] dividend,
    input  wire logic [23:0] divisor,
    output logic      [23:0] quotient,
    output logic             ovf
);

    logic [23:0] rem_reg  [0:rcft_pkg::DIV_STAGES-1];
    logic [23:0] low_reg  [0:rcft_pkg::DIV_STAGES-1];
    logic [23:0] den_reg  [0:rcft_pkg::DIV_STAGES-1];
    logic [23:0] quo_reg  [0:rcft_pkg::DIV_STAGES-1];
    logic        ovf_reg  [0:rcft_pkg::DIV_STAGES-1];

    logic [23:0] rem_in   [0:rcft_pkg::DIV_STAGES-1];
    logic [23:0] low_in   [0:rcft_pkg::DIV_STAGES-1];
    logic [23:0] den_in   [0:rcft_pkg::DIV_STAGES-1];
    logic [23:0] quo_in   [0:rcft_pkg::DIV_STAGES-1];
    logic        ovf_in   [0:rcft_pkg::DIV_STAGES-1];

    logic [23:0] rem_next [0:rcft_pkg::DIV_STAGES-1];
    logic [23:0] quo_next [0:rcft_pkg::DIV_STAGES-1];

    always_comb begin
        logic [24:0] trial;
        logic [23:0] r;
        logic [23:0] q;
        rem_in[0] = {8'd0, dividend[39:24]};
        low_in[0] = dividend[23:0];
        den_in[0] = divisor;
        quo_in[0] = 24'd0;
        ovf_in[0] = ({8'd0, dividend[39:24]} >= divisor);
        for (int s = 1; s < rcft_pkg::DIV_STAGES; s++) begin
            rem_in[s] = rem_reg[s-1];
            low_in[s] = low_reg[s-1];
            den_in[s] = den_reg[s-1];
            quo_in[s] = quo_reg[s-1];
            ovf_in[s] = ovf_reg[s-1];
        end
        for (int s = 0; s < rcft_pkg::DIV_STAGES; s++) begin
            r = rem_in[s];
            q = quo_in[s];
            for (int b = 0; b < 4; b++) begin
                trial = {r, low_in[s][23-b]};
                if (trial >= {1'b0, den_in[s]}) begin
                    r = 24'(trial - {1'b0, den_in[s]});
                    q = {q[22:0], 1'b1};
                end else begin
                    r = trial[23:0];
                    q = {q[22:0], 1'b0};
                end
            end
            rem_next[s] = r;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < rcft_pkg::DIV_STAGES; s++) begin
                rem_reg[s] <= rem_next[s];
                low_reg[s] <= {low_in[s][19:0], 4'd0};
                den_reg[s] <= den_in[s];
                quo_reg[s] <= quo_next[s];
                ovf_reg[s] <= ovf_in[s];
            end
        end
    end

    assign quotient = quo_reg[rcft_pkg::DIV_STAGES-1];
    assign ovf      = ovf_reg[rcft_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/core/rcft_tex_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcft_tex_mem
// Texture store: floor A and B in one memory, ceiling in another, each with
// one port that either writes a loaded texel or reads with a registered output.
// ----------------------------------------------------------------------------
module rcft_tex_mem (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic        load,
    input  wire logic [1:0]  sel,
    input  wire logic [11:0] wr_index,
    input  wire logic [31:0] wr_data,
    input  wire logic        rd_parity,
    input  wire logic [11:0] rd_index,
    output logic      [31:0] floor_q,
    output logic      [31:0] ceil_q
);

    logic [31:0] floor_mem [0:8191];
    logic [31:0] ceil_mem  [0:4095];

    logic        floor_we;
    logic        ceil_we;
    logic [12:0] floor_addr;
    logic [11:0] ceil_addr;

    assign floor_we   = load && (sel == rcft_pkg::TEX_FLOOR_A || sel == rcft_pkg::TEX_FLOOR_B);
    assign ceil_we    = load && (sel == rcft_pkg::TEX_CEILING);
    assign floor_addr = load ? {sel[0], wr_index} : {rd_parity, rd_index};
    assign ceil_addr  = load ? wr_index : rd_index;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (floor_we) begin
                floor_mem[floor_addr] <= wr_data;
            end else begin
                floor_q <= floor_mem[floor_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ceil_we) begin
                ceil_mem[ceil_addr] <= wr_data;
            end else begin
                ceil_q <= ceil_mem[ceil_addr];
            end
        end
    end

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the floor and ceiling texel caster. Texel loads and
// cast rows are streamed in with random gaps, while a shadow texture store
// and a fixed-point row caster predict every pixel pair, which is checked
// field by field.
// ----------------------------------------------------------------------------

class pixel_scoreboard;
    bit [31:0] tex_words[3*4096];
    bit        tex_written[3*4096];
    bit [87:0] pending_pixels[$];
    bit        pending_status[$];
    int        errors = 0;

    // Works out the pixel pair of one cast row; the two addresses are those read.
    function automatic bit cast_row(input bit [183:0] d, output bit [87:0] px_out,
                                    output int floor_addr, output int ceil_addr);
        bit [9:0]  col, rw;
        bit [23:0] wd, fx, fy, ppx, ppy;
        bit [63:0] denom, cd, wgt, cfx, cfy;
        bit [5:0]  tx, ty;
        bit [11:0] ti;
        col = d[53:44];   rw = d[63:54];    wd = d[87:64];
        fx = d[111:88];   fy = d[135:112];  ppx = d[159:136]; ppy = d[183:160];
        px_out = '0;
        px_out[9:0] = col;
        px_out[19:10] = rw;
        floor_addr = 0;
        ceil_addr = 0;
        if (2 * rw <= rcft_pkg::SCREEN_HEIGHT || rw >= rcft_pkg::SCREEN_HEIGHT
            || col >= rcft_pkg::SCREEN_WIDTH)
            return 1'b1;
        denom = 64'(2 * rw - rcft_pkg::SCREEN_HEIGHT);
        cd = (64'(rcft_pkg::SCREEN_HEIGHT) << 16) / denom;
        if (cd > 64'hFFFFFF) cd = 64'hFFFFFF;
        if (wd == 0) begin
            wgt = 64'h10000;
        end else begin
            wgt = (cd << 16) / wd;
            if (wgt > 64'h10000) wgt = 64'h10000;
        end
        cfx = (wgt * fx + (64'h10000 - wgt) * ppx) >> 16;
        cfy = (wgt * fy + (64'h10000 - wgt) * ppy) >> 16;
        tx = cfx[15:10];
        ty = cfy[15:10];
        ti = {ty, tx};
        floor_addr = ((cfx[16] ^ cfy[16]) ? 4096 : 0) + ti;
        ceil_addr = 2 * 4096 + ti;
        px_out[43:20] = 24'((tex_words[floor_addr] >> 1) & 32'h7F7F7F);
        px_out[53:44] = 10'(rcft_pkg::SCREEN_HEIGHT - rw);
        px_out[85:54] = tex_words[ceil_addr];
        return 1'b0;
    endfunction

    function void note_input(bit [2:0] user, bit [183:0] d);
        bit [87:0] px;
        int fa, ca;
        bit st;
        if (user[0] == rcft_pkg::MODE_LOAD) begin
            if (user[2:1] != 2'd3) begin
                tex_words[user[2:1] * 4096 + d[11:0]] = d[43:12];
                tex_written[user[2:1] * 4096 + d[11:0]] = 1'b1;
            end
        end else begin
            st = cast_row(d, px, fa, ca);
            pending_pixels.push_back(px);
            pending_status.push_back(st);
        end
    endfunction

    function void check_result(bit [87:0] d, bit st);
        bit [87:0] e;
        bit es;
        if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected word, actual %h status %b", $time, d, st);
            errors++;
            return;
        end
        e = pending_pixels.pop_front();
        es = pending_status.pop_front();
        if (d[9:0] != e[9:0]) begin
            $display("%0t: out_column expected %0d actual %0d", $time, e[9:0], d[9:0]);
            errors++;
        end
        if (d[19:10] != e[19:10]) begin
            $display("%0t: floor_row expected %0d actual %0d", $time, e[19:10], d[19:10]);
            errors++;
        end
        if (d[43:20] != e[43:20]) begin
            $display("%0t: floor_color expected %h actual %h", $time, e[43:20], d[43:20]);
            errors++;
        end
        if (d[53:44] != e[53:44]) begin
            $display("%0t: ceiling_row expected %0d actual %0d", $time, e[53:44], d[53:44]);
            errors++;
        end
        if (d[85:54] != e[85:54]) begin
            $display("%0t: ceiling_color expected %h actual %h", $time, e[85:54], d[85:54]);
            errors++;
        end
        if (st != es) begin
            $display("%0t: status expected %b actual %b", $time, es, st);
            errors++;
        end
    endfunction
endclass

module tb;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;
    logic [0:0]   m_tuser;

    pixel_scoreboard sb = new();
    bit quiet = 1'b0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_cycles = 0;
    int idle_count = 0;
    int idle_count_wd = 0;

    raycast_floor_ceiling_texel_core dut (.*);

    always #5 aclk = ~aclk;

    task automatic send_word(bit [2:0] user, bit [183:0] d);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = user;
        s_tdata = d;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(user, d);
        @(negedge aclk);
    endtask

    task automatic load_texel(bit [1:0] sel, bit [11:0] idx, bit [31:0] val);
        bit [183:0] d;
        d = 184'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        d[11:0] = idx;
        d[43:12] = val;
        send_word({sel, rcft_pkg::MODE_LOAD}, d);
    endtask

    // Loads any texel the cast would read that has not been written yet.
    task automatic cast(bit [9:0] col, bit [9:0] rw, bit [23:0] wd, bit [23:0] fx,
                        bit [23:0] fy, bit [23:0] ppx, bit [23:0] ppy);
        bit [183:0] d;
        bit [87:0] px;
        int fa, ca;
        d = {ppy, ppx, fy, fx, wd, rw, col, $urandom, 12'($urandom)};
        if (!sb.cast_row(d, px, fa, ca)) begin
            if (!sb.tex_written[fa]) load_texel(2'(fa / 4096), 12'(fa % 4096), $urandom);
            if (!sb.tex_written[ca]) load_texel(rcft_pkg::TEX_CEILING, 12'(ca % 4096),
                                                $urandom);
        end
        send_word({2'($urandom), rcft_pkg::MODE_CAST}, d);
    endtask

    function automatic bit [23:0] rand_q();
        return 24'($urandom) >> $urandom_range(0, 23);
    endfunction

    always @(negedge aclk) begin
        if (hold_go && !hold_done) begin
            m_tready <= 1'b0;
            hold_cycles <= 299;
            hold_done <= 1'b1;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (idle_count > 0) begin
            m_tready <= 1'b0;
            idle_count <= idle_count - 1;
        end else if (aresetn && !quiet && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            idle_count <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_count_wd = 0;
        end else begin
            idle_count_wd++;
            if (idle_count_wd >= 3000) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        load_texel(rcft_pkg::TEX_FLOOR_A, 12'hFFF, 32'hFFFFFFFF);
        load_texel(rcft_pkg::TEX_FLOOR_B, 12'h000, 32'h00000000);
        load_texel(rcft_pkg::TEX_CEILING, 12'hA5A, 32'hA5A5A5A5);
        load_texel(2'd3, 12'h123, 32'hDEADBEEF);
        cast(10'd0, 10'd0, 24'h010000, 0, 0, 0, 0);
        cast(10'd5, 10'd240, 24'h010000, 0, 0, 0, 0);
        cast(10'd5, 10'd241, 24'h010000, 24'h123456, 24'h654321, 24'h0, 24'h0);
        cast(10'd639, 10'd479, 24'h000001, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
        cast(10'd640, 10'd300, 24'h010000, 0, 0, 0, 0);
        cast(10'd1023, 10'd1023, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        cast(10'd100, 10'd480, 24'h010000, 0, 0, 0, 0);
        cast(10'd100, 10'd300, 24'h000000, 24'h0A8000, 24'h038000, 24'h010000, 24'h020000);
        cast(10'd100, 10'd300, 24'hFFFFFF, 24'h0A8000, 24'h038000, 24'hFFFFFF, 24'h000000);
        cast(10'd0, 10'd400, 24'h040000, 24'h008000, 24'h018000, 24'h000000, 24'hFFFFFF);

        for (int i = 0; i < 320; i++) begin
            if (i == 120) hold_go = 1'b1;
            if (i == 280) quiet = 1'b1;
            case ($urandom_range(0, 9))
                0, 1: load_texel(2'($urandom), 12'($urandom), $urandom);
                2: cast(10'($urandom), 10'($urandom), rand_q(), rand_q(), rand_q(),
                        rand_q(), rand_q());
                default: cast(10'($urandom_range(0, rcft_pkg::SCREEN_WIDTH - 1)),
                              10'($urandom_range(rcft_pkg::SCREEN_HEIGHT / 2 + 1,
                                                 rcft_pkg::SCREEN_HEIGHT - 1)),
                              rand_q(), 24'($urandom), 24'($urandom), 24'($urandom),
                              24'($urandom));
            endcase
        end
        s_tvalid = 1'b0;

        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
